FILE: hw/rtl/rwmp_pkg.sv
package rwmp_pkg;

  // configuration register map
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_PCT  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SECOND_PCT = 2'd1;

  // percentile points, hundredths of a percent
  localparam int PCT_BITS = 14;
  localparam logic [PCT_BITS-1:0] PCT_FULL         = 14'd10000;
  localparam logic [PCT_BITS-1:0] FIRST_PCT_RESET  = 14'd9500;
  localparam logic [PCT_BITS-1:0] SECOND_PCT_RESET = 14'd9900;

  // interpolation fraction
  localparam int FRAC_BITS = 16;
  // frac = rem * 65536 / 10000 = rem * 4096 / 625, rem < 10000;
  // taken as (rem * ceil(2^36 / 625)) >> 24, exact over that range
  localparam int FRAC_SHIFT      = 24;
  localparam int FRAC_RECIP_BITS = 27;
  localparam logic [FRAC_RECIP_BITS-1:0] FRAC_RECIP = 27'd109951163;

  // number of order statistics selected per sample
  localparam int LANES = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MEAN_START,
    ST_MEAN_WAIT,
    ST_POS_MUL,
    ST_POS_QUO,
    ST_POS_REM,
    ST_FRAC,
    ST_SCAN,
    ST_DECIDE,
    ST_INTERP_MUL,
    ST_INTERP_ADD,
    ST_OUT
  } state_t;

endpackage

FILE: hw/rtl/rolling_window_mean_percentile.sv
// Rolling window of timing samples with mean and two interpolated percentiles.
// Input channel (in_valid/in_ready, in_sample_us): one beat pushes one sample
// into a ring of WINDOW_DEPTH entries, overwriting the oldest once full.
// Output channel (out_valid/out_ready): one beat per sample with the truncated
// mean, the values at the two percentile points and the current fill.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sets the first
// point, index 1 the second, in hundredths of a percent; other indexes are
// ignored. Write only while the block is idle.
// The divider is DW bits wide (32 at defaults). The order statistics come from a
// radix select that sweeps the sample memory once per sample bit, four ranks
// in parallel, one memory read per cycle; the mean uses a one-bit-per-cycle
// divider, the positions and fractions reciprocal multiplies.
// One sample is processed at a time; in_ready is high only when idle, so no
// new sample is taken before the last one has left the output state.
// A finished result waits in the output register; if the receiver stalls,
// the next sample is still accepted and processed, and holds at the end
// until the output register frees.
// Reset clears pointer, fill, sum and points (9500, 9900); no memory sweep.
module rolling_window_mean_percentile #(
  parameter int WINDOW_DEPTH = 256,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [SAMPLE_BITS-1:0]                  in_sample_us,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [SAMPLE_BITS-1:0]                  out_mean_us,
  output logic [SAMPLE_BITS-1:0]                  out_first_value_us,
  output logic [SAMPLE_BITS-1:0]                  out_second_value_us,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]       out_window_fill,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [rwmp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [rwmp_pkg::PCT_BITS-1:0]           cfg_data
);

  localparam int AW   = $clog2(WINDOW_DEPTH);
  localparam int FW   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUMW = SAMPLE_BITS + AW;
  localparam int DW   = SUMW;
  localparam int FB   = rwmp_pkg::FRAC_BITS;
  localparam int PB   = rwmp_pkg::PCT_BITS;
  localparam int NL   = rwmp_pkg::LANES;
  // position = point * last, divided by 10000 through a reciprocal:
  // (scaled * ceil(2^k / 10000)) >> k is exact for scaled < 2^(k - PB)
  localparam int SCW       = PB + FW;
  localparam int POS_SHIFT = SCW + PB;
  localparam int POS_MW    = SCW + 1;
  localparam int PW        = SCW + POS_MW;
  localparam longint unsigned POS_RECIP =
    ((64'd1 << POS_SHIFT) + 64'(rwmp_pkg::PCT_FULL) - 64'd1) / 64'(rwmp_pkg::PCT_FULL);
  localparam int FPW = PB + rwmp_pkg::FRAC_RECIP_BITS;

  rwmp_pkg::state_t state_r, state_nxt;

  logic [PB-1:0]          first_pct_r, second_pct_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [AW-1:0]          wptr_r;
  logic [FW-1:0]          fill_r;
  logic [SUMW-1:0]        sum_r;
  logic                   pi_r;
  logic [SCW-1:0]         scaled_r;
  logic [PB-1:0]          rem_r;
  logic [FW-1:0]          lo_r [2];
  logic [FB-1:0]          frac_r [2];
  logic [SAMPLE_BITS-1:0] mean_r;
  logic [SAMPLE_BITS-1:0] val_r [2];
  logic [SAMPLE_BITS+FB-1:0] prod_r;

  // radix select lanes: lo0, hi0, lo1, hi1
  logic [SAMPLE_BITS-1:0] pref_r [NL];
  logic [FW-1:0]          rank_r [NL];
  logic [FW-1:0]          cnt_r  [NL];
  logic [SAMPLE_BITS-1:0] bit_r;
  logic [SAMPLE_BITS-1:0] mask_r;
  logic [FW-1:0]          addr_cnt_r;
  logic                   rd_vld_r;
  logic [NL-1:0]          match;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_mean_r, out_first_r, out_second_r;
  logic [FW-1:0]          out_fill_r;

  logic                   ram_we;
  logic [AW-1:0]          ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic                   div_start;
  logic [DW-1:0]          div_dividend, div_divisor;
  logic                   div_done;
  logic [DW-1:0]          div_quo;

  logic [FW-1:0]          last;
  logic [PB-1:0]          p_raw, p_sat;
  logic [FW-1:0]          hi0, hi1;
  logic [SAMPLE_BITS-1:0] vlo, vhi;
  logic [PW-1:0]          pos_prod;
  logic [FPW-1:0]         frac_prod;
  logic                   accept_in, out_free, scan_issue;

  assign accept_in  = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign last       = fill_r - 1'b1;
  assign p_raw      = pi_r ? second_pct_r : first_pct_r;
  assign p_sat      = (p_raw > rwmp_pkg::PCT_FULL) ? rwmp_pkg::PCT_FULL : p_raw;
  assign hi0        = (lo_r[0] == last) ? lo_r[0] : lo_r[0] + 1'b1;
  assign hi1        = (lo_r[1] == last) ? lo_r[1] : lo_r[1] + 1'b1;
  assign vlo        = pi_r ? pref_r[2] : pref_r[0];
  assign vhi        = pi_r ? pref_r[3] : pref_r[1];
  assign scan_issue = (state_r == rwmp_pkg::ST_SCAN) && (addr_cnt_r != fill_r);
  assign pos_prod   = PW'(scaled_r) * PW'(POS_RECIP);
  assign frac_prod  = FPW'(rem_r) * FPW'(rwmp_pkg::FRAC_RECIP);

  rwmp_sample_ram #(
    .DEPTH(WINDOW_DEPTH),
    .WIDTH(SAMPLE_BITS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wptr_r),
    .wdata(sample_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rwmp_divider #(
    .WIDTH(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rwmp_pkg::ST_IDLE:       if (in_valid) state_nxt = rwmp_pkg::ST_UPDATE;
      rwmp_pkg::ST_UPDATE:     state_nxt = rwmp_pkg::ST_MEAN_START;
      rwmp_pkg::ST_MEAN_START: state_nxt = rwmp_pkg::ST_MEAN_WAIT;
      rwmp_pkg::ST_MEAN_WAIT:  if (div_done) state_nxt = rwmp_pkg::ST_POS_MUL;
      rwmp_pkg::ST_POS_MUL:    state_nxt = rwmp_pkg::ST_POS_QUO;
      rwmp_pkg::ST_POS_QUO:    state_nxt = rwmp_pkg::ST_POS_REM;
      rwmp_pkg::ST_POS_REM:    state_nxt = rwmp_pkg::ST_FRAC;
      rwmp_pkg::ST_FRAC: begin
        state_nxt = pi_r ? rwmp_pkg::ST_SCAN : rwmp_pkg::ST_POS_MUL;
      end
      rwmp_pkg::ST_SCAN: begin
        if ((addr_cnt_r == fill_r) && !rd_vld_r) state_nxt = rwmp_pkg::ST_DECIDE;
      end
      rwmp_pkg::ST_DECIDE: begin
        state_nxt = bit_r[0] ? rwmp_pkg::ST_INTERP_MUL : rwmp_pkg::ST_SCAN;
      end
      rwmp_pkg::ST_INTERP_MUL: state_nxt = rwmp_pkg::ST_INTERP_ADD;
      rwmp_pkg::ST_INTERP_ADD: begin
        state_nxt = pi_r ? rwmp_pkg::ST_OUT : rwmp_pkg::ST_INTERP_MUL;
      end
      rwmp_pkg::ST_OUT:        if (out_free) state_nxt = rwmp_pkg::ST_IDLE;
      default:                 state_nxt = rwmp_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_raddr    = addr_cnt_r[AW-1:0];
    div_start    = 1'b0;
    div_dividend = DW'(sum_r);
    div_divisor  = DW'(fill_r);
    case (state_r)
      rwmp_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = wptr_r;
      end
      rwmp_pkg::ST_UPDATE: ram_we = 1'b1;
      rwmp_pkg::ST_MEAN_START: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  // lane compares against the prefix decided so far
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      match[l] = (((ram_rdata ^ pref_r[l]) & mask_r) == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rwmp_pkg::ST_IDLE;
      first_pct_r  <= rwmp_pkg::FIRST_PCT_RESET;
      second_pct_r <= rwmp_pkg::SECOND_PCT_RESET;
      wptr_r       <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      pi_r         <= 1'b0;
      rd_vld_r     <= 1'b0;
      addr_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == rwmp_pkg::CFG_FIRST_PCT) first_pct_r <= cfg_data;
        else if (cfg_index == rwmp_pkg::CFG_SECOND_PCT) second_pct_r <= cfg_data;
      end
      // result beat: load on leaving the output state, drop once taken
      if (state_r == rwmp_pkg::ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      rd_vld_r <= scan_issue;
      if (scan_issue) addr_cnt_r <= addr_cnt_r + 1'b1;
      case (state_r)
        rwmp_pkg::ST_UPDATE: begin
          if (fill_r == FW'(WINDOW_DEPTH)) begin
            sum_r <= sum_r - SUMW'(ram_rdata) + SUMW'(sample_r);
          end else begin
            sum_r  <= sum_r + SUMW'(sample_r);
            fill_r <= fill_r + 1'b1;
          end
          wptr_r <= (wptr_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
        end
        rwmp_pkg::ST_FRAC: begin
          pi_r       <= !pi_r;
          addr_cnt_r <= '0;
        end
        rwmp_pkg::ST_DECIDE: addr_cnt_r <= '0;
        rwmp_pkg::ST_INTERP_ADD: pi_r <= !pi_r;
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept_in) sample_r <= in_sample_us;
    case (state_r)
      rwmp_pkg::ST_MEAN_WAIT: if (div_done) mean_r <= div_quo[SAMPLE_BITS-1:0];
      rwmp_pkg::ST_POS_MUL:   scaled_r <= SCW'(p_sat) * SCW'(last);
      rwmp_pkg::ST_POS_QUO:   lo_r[pi_r] <= pos_prod[POS_SHIFT +: FW];
      rwmp_pkg::ST_POS_REM: begin
        rem_r <= PB'(scaled_r - SCW'(lo_r[pi_r]) * SCW'(rwmp_pkg::PCT_FULL));
      end
      rwmp_pkg::ST_FRAC: begin
        frac_r[pi_r] <= frac_prod[rwmp_pkg::FRAC_SHIFT +: FB];
        // set up the radix select once both positions are known
        if (pi_r) begin
          rank_r[0] <= lo_r[0];
          rank_r[1] <= hi0;
          rank_r[2] <= lo_r[1];
          rank_r[3] <= hi1;
          for (int l = 0; l < NL; l++) begin
            pref_r[l] <= '0;
            cnt_r[l]  <= '0;
          end
          bit_r  <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          mask_r <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
      end
      rwmp_pkg::ST_SCAN: begin
        if (rd_vld_r) begin
          for (int l = 0; l < NL; l++) begin
            if (match[l]) cnt_r[l] <= cnt_r[l] + 1'b1;
          end
        end
      end
      rwmp_pkg::ST_DECIDE: begin
        // rank at or past the zero-bit count: this bit is one
        for (int l = 0; l < NL; l++) begin
          if (rank_r[l] >= cnt_r[l]) begin
            pref_r[l] <= pref_r[l] | bit_r;
            rank_r[l] <= rank_r[l] - cnt_r[l];
          end
          cnt_r[l] <= '0;
        end
        bit_r  <= bit_r >> 1;
        mask_r <= {1'b1, mask_r[SAMPLE_BITS-1:1]};
      end
      rwmp_pkg::ST_INTERP_MUL: begin
        prod_r <= (SAMPLE_BITS+FB)'(vhi - vlo)
                  * (SAMPLE_BITS+FB)'(pi_r ? frac_r[1] : frac_r[0]);
      end
      rwmp_pkg::ST_INTERP_ADD: val_r[pi_r] <= vlo + prod_r[SAMPLE_BITS+FB-1:FB];
      rwmp_pkg::ST_OUT: begin
        if (out_free) begin
          out_mean_r   <= mean_r;
          out_first_r  <= val_r[0];
          out_second_r <= val_r[1];
          out_fill_r   <= fill_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_mean_us         = out_mean_r;
  assign out_first_value_us  = out_first_r;
  assign out_second_value_us = out_second_r;
  assign out_window_fill     = out_fill_r;

`ifndef SYNTHESIS
  a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    accept_in |=> state_r == rwmp_pkg::ST_UPDATE)
    else $error("accepted beat did not start a window update");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == rwmp_pkg::ST_MEAN_WAIT)
    else $error("divider finished outside the mean wait state");

  a_full_stays_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rwmp_pkg::ST_UPDATE && fill_r == FW'(WINDOW_DEPTH))
    |=> fill_r == FW'(WINDOW_DEPTH))
    else $error("fill changed on a full window");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rwmp_pkg::ST_OUT))
    else $error("result beat raised outside the output state");
`endif

endmodule

FILE: hw/rtl/rwmp_sample_ram.sv
module rwmp_sample_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rwmp_divider.sv
module rwmp_divider #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_r, quo_r[WIDTH-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (!diff[WIDTH]) begin
      rem_nxt = diff[WIDTH-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[WIDTH-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
